FILE: hdl/ght_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ght_pkg;

  // table geometry
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // field widths
  localparam int OP_W     = 2;
  localparam int WORD_W   = 32;
  localparam int HANDLE_W = 64;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int ENC_W    = 24;
  localparam int TAG_W    = 8;

  // handle tag
  localparam logic [TAG_W-1:0] HANDLE_TAG = 8'h43;

  // operation codes
  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
  localparam logic [OP_W-1:0] OP_RETAIN  = 2'd2;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IN_USE      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CAPACITY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_VERSION = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TOO_SMALL   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ABI_VERSION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE    = 1'd1;

  localparam logic [WORD_W-1:0] CFG_ABI_RESET  = 32'd1;
  localparam logic [WORD_W-1:0] CFG_SIZE_RESET = 32'd16;
  localparam logic [WORD_W-1:0] COUNT_MAX      = 32'hffff_ffff;

  // slot memory word: generation over reference count
  localparam int SLOT_WORD_W = 2 * WORD_W;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture transaction and issue slot read
    logic exec;  // update slot and present result
  } ght_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/ght_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/ght_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ght_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  output ght_pkg::ght_cmd_t    cmd
);
  import ght_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands and status
  assign busy     = (state_r == ST_EXEC);
  assign cmd.load = (state_r == ST_IDLE) && start;
  assign cmd.exec = (state_r == ST_EXEC);

endmodule
`default_nettype wire

FILE: hdl/ght_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module ght_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  ght_pkg::ght_cmd_t                       cmd,
  input  wire logic [ght_pkg::OP_W-1:0]           in_operation,
  input  wire logic [ght_pkg::HANDLE_W-1:0]       in_handle,
  input  wire logic [ght_pkg::WORD_W-1:0]         in_desc_abi_version,
  input  wire logic [ght_pkg::WORD_W-1:0]         in_desc_struct_size,
  input  wire logic [ght_pkg::WORD_W-1:0]         in_desc_flags,
  input  wire logic [ght_pkg::WORD_W-1:0]         in_desc_reserved,
  input  wire logic                               cfg_write,
  input  wire logic [ght_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ght_pkg::WORD_W-1:0]         cfg_data,
  output logic                                    out_valid,
  output logic [ght_pkg::STATUS_W-1:0]            out_status,
  output logic [ght_pkg::HANDLE_W-1:0]            out_new_handle
);
  import ght_pkg::*;

  // configuration registers
  logic [WORD_W-1:0] abi_version_r;
  logic [WORD_W-1:0] min_size_r;

  // per-slot flags
  logic [SLOT_COUNT-1:0] active_r;
  logic [SLOT_COUNT-1:0] written_r;

  // captured transaction
  logic [OP_W-1:0]     op_r;
  logic [WORD_W-1:0]   hgen_r;
  logic                hfmt_ok_r;
  logic [SLOT_W-1:0]   idx_r;
  logic [STATUS_W-1:0] create_st_r;

  // result registers
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [HANDLE_W-1:0] out_handle_r;

  // lowest inactive slot
  logic [SLOT_W-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  // handle decode
  logic [WORD_W-1:0] h_gen;
  logic [TAG_W-1:0]  h_tag;
  logic [ENC_W-1:0]  h_enc;
  logic [ENC_W-1:0]  h_enc_m1;
  logic              h_fmt_ok;
  assign h_gen    = in_handle[HANDLE_W-1:WORD_W];
  assign h_tag    = in_handle[WORD_W-1:WORD_W-TAG_W];
  assign h_enc    = in_handle[ENC_W-1:0];
  assign h_enc_m1 = h_enc - ENC_W'(1);
  assign h_fmt_ok = (h_gen != '0) && (h_tag == HANDLE_TAG) && (h_enc != '0)
                    && (h_enc <= ENC_W'(SLOT_COUNT));

  // descriptor checks for create
  logic [STATUS_W-1:0] create_st;
  always_comb begin
    if (in_desc_abi_version != abi_version_r) begin
      create_st = ST_BAD_VERSION;
    end else if (in_desc_struct_size < min_size_r) begin
      create_st = ST_TOO_SMALL;
    end else if ((in_desc_flags != '0) || (in_desc_reserved != '0)) begin
      create_st = ST_UNSUPPORTED;
    end else if (&active_r) begin
      create_st = ST_CAPACITY;
    end else begin
      create_st = ST_OK;
    end
  end

  // slot read address chosen at capture
  logic [SLOT_W-1:0] rd_idx;
  assign rd_idx = (in_operation == OP_CREATE) ? free_idx : h_enc_m1[SLOT_W-1:0];

  // capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_operation;
      hgen_r      <= h_gen;
      hfmt_ok_r   <= h_fmt_ok;
      idx_r       <= rd_idx;
      create_st_r <= create_st;
    end
  end

  // slot memory
  logic                   ram_we;
  logic [SLOT_WORD_W-1:0] ram_wdata;
  logic [SLOT_WORD_W-1:0] ram_rdata;

  ght_ram #(
    .WIDTH (SLOT_WORD_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // slot contents; never-written generation reads as zero
  logic [WORD_W-1:0] cur_gen;
  logic [WORD_W-1:0] cur_cnt;
  logic              live;
  logic [WORD_W-1:0] gen_bumped;
  logic [WORD_W-1:0] gen_create;
  assign cur_gen    = written_r[idx_r] ? ram_rdata[SLOT_WORD_W-1:WORD_W] : '0;
  assign cur_cnt    = ram_rdata[WORD_W-1:0];
  assign live       = hfmt_ok_r && active_r[idx_r] && (cur_gen == hgen_r);
  assign gen_bumped = (cur_gen == COUNT_MAX) ? WORD_W'(1) : cur_gen + WORD_W'(1);
  assign gen_create = (cur_gen == '0) ? WORD_W'(1) : cur_gen;

  // operation execute
  logic                   set_active;
  logic                   clr_active;
  logic [STATUS_W-1:0]    res_status;
  logic [HANDLE_W-1:0]    res_handle;
  always_comb begin
    ram_we     = 1'b0;
    ram_wdata  = {cur_gen, cur_cnt};
    set_active = 1'b0;
    clr_active = 1'b0;
    res_status = ST_OK;
    res_handle = '0;
    case (op_r)
      OP_CREATE: begin
        res_status = create_st_r;
        if (create_st_r == ST_OK) begin
          ram_we     = 1'b1;
          ram_wdata  = {gen_create, WORD_W'(0)};
          set_active = 1'b1;
          res_handle = {gen_create, HANDLE_TAG, ENC_W'(idx_r) + ENC_W'(1)};
        end
      end
      OP_DESTROY: begin
        if (!live) begin
          res_status = ST_BAD_HANDLE;
        end else if (cur_cnt != '0) begin
          res_status = ST_IN_USE;
        end else begin
          ram_we     = 1'b1;
          ram_wdata  = {gen_bumped, cur_cnt};
          clr_active = 1'b1;
        end
      end
      OP_RETAIN: begin
        if (!live) begin
          res_status = ST_BAD_HANDLE;
        end else if (cur_cnt == COUNT_MAX) begin
          res_status = ST_CAPACITY;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = {cur_gen, cur_cnt + WORD_W'(1)};
        end
      end
      default: begin
        if (live && (cur_cnt != '0)) begin
          ram_we    = 1'b1;
          ram_wdata = {cur_gen, cur_cnt - WORD_W'(1)};
        end
      end
    endcase
    if (!cmd.exec) begin
      ram_we     = 1'b0;
      set_active = 1'b0;
      clr_active = 1'b0;
    end
  end

  // control state: config, slot flags, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abi_version_r <= CFG_ABI_RESET;
      min_size_r    <= CFG_SIZE_RESET;
      active_r      <= '0;
      written_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_ABI_VERSION: abi_version_r <= cfg_data;
          CFG_MIN_SIZE:    min_size_r    <= cfg_data;
          default: begin
          end
        endcase
      end
      if (set_active) begin
        active_r[idx_r]  <= 1'b1;
        written_r[idx_r] <= 1'b1;
      end
      if (clr_active) begin
        active_r[idx_r] <= 1'b0;
      end
      out_valid_r <= cmd.exec;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r <= res_status;
      out_handle_r <= res_handle;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_new_handle = out_handle_r;

endmodule
`default_nettype wire

FILE: hdl/generational_handle_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Generational handle table with 16 slots. Raise start with an operation
// (create, destroy, retain, release) while busy is low; the transaction is
// taken at that edge. Each operation first picks the slot (lowest free slot
// for create, or the slot decoded from the handle) and reads the slot
// memory, then checks and writes the slot back. The result appears on
// out_status and out_new_handle with out_valid high for exactly one cycle,
// as busy falls, and must be taken then: there is no back-pressure. A new
// start may be given in that same cycle; no new transaction is taken while
// busy is high. Configuration writes are always ready and take effect at
// once; make them only while no transaction is in flight.
module generational_handle_table (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [ght_pkg::OP_W-1:0]          in_operation,
  input  wire logic [ght_pkg::HANDLE_W-1:0]      in_handle,
  input  wire logic [ght_pkg::WORD_W-1:0]        in_desc_abi_version,
  input  wire logic [ght_pkg::WORD_W-1:0]        in_desc_struct_size,
  input  wire logic [ght_pkg::WORD_W-1:0]        in_desc_flags,
  input  wire logic [ght_pkg::WORD_W-1:0]        in_desc_reserved,
  output logic                                   out_valid,
  output logic [ght_pkg::STATUS_W-1:0]           out_status,
  output logic [ght_pkg::HANDLE_W-1:0]           out_new_handle,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ght_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ght_pkg::WORD_W-1:0]        cfg_data
);
  import ght_pkg::*;

  ght_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // sequencer
  ght_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // slot storage and checks
  ght_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_operation        (in_operation),
    .in_handle           (in_handle),
    .in_desc_abi_version (in_desc_abi_version),
    .in_desc_struct_size (in_desc_struct_size),
    .in_desc_flags       (in_desc_flags),
    .in_desc_reserved    (in_desc_reserved),
    .cfg_write           (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_new_handle      (out_new_handle)
  );

  // every accepted transaction yields a result after its execute cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted transaction produced no result");

  // a result only follows an execute cycle
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.exec))
    else $error("result strobe without execute cycle");

  // a handle is returned only with ok status
  a_handle_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_new_handle == '0))
    else $error("non-zero handle with failing status");

  // load and execute never overlap
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.exec))
    else $error("load and execute in the same cycle");

endmodule
`default_nettype wire

FILE: tb/tb_generational_handle_table.sv
`timescale 1ns / 1ps
module tb_generational_handle_table;
  import ght_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
    logic [WORD_W-1:0]   ver;
    logic [WORD_W-1:0]   size;
    logic [WORD_W-1:0]   flags;
    logic [WORD_W-1:0]   rsv;
  } table_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] new_handle;
  } table_rsp_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      in_operation;
  logic [HANDLE_W-1:0]  in_handle;
  logic [WORD_W-1:0]    in_desc_abi_version;
  logic [WORD_W-1:0]    in_desc_struct_size;
  logic [WORD_W-1:0]    in_desc_flags;
  logic [WORD_W-1:0]    in_desc_reserved;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [HANDLE_W-1:0]  out_new_handle;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  // shadow of the slot table and its settings
  bit                slot_live [SLOT_COUNT];
  logic [WORD_W-1:0] slot_gen  [SLOT_COUNT];
  logic [WORD_W-1:0] slot_refs [SLOT_COUNT];
  logic [WORD_W-1:0] abi_setting;
  logic [WORD_W-1:0] min_size_setting;

  table_req_t  op_queue[$];
  table_rsp_t  awaited_outcomes[$];
  int unsigned drive_count  = 0;
  int unsigned accept_count = 0;
  int unsigned cycle_count  = 0;
  int          err_count    = 0;
  int          gap_pct      = 0;

  generational_handle_table i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_handle           (in_handle),
    .in_desc_abi_version (in_desc_abi_version),
    .in_desc_struct_size (in_desc_struct_size),
    .in_desc_flags       (in_desc_flags),
    .in_desc_reserved    (in_desc_reserved),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_new_handle      (out_new_handle),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [HANDLE_W-1:0] make_handle(input logic [WORD_W-1:0] gen,
                                                      input int slot);
    return {gen, HANDLE_TAG, ENC_W'(slot + 1)};
  endfunction

  // handle lookup: tag, slot range, non-zero generation, live slot, matching generation
  function automatic bit locate_slot(input logic [HANDLE_W-1:0] h, output int idx);
    logic [WORD_W-1:0] gen;
    logic [ENC_W-1:0]  enc;
    gen = h[HANDLE_W-1:WORD_W];
    enc = h[ENC_W-1:0];
    idx = 0;
    if (gen == '0 || h[WORD_W-1:ENC_W] != HANDLE_TAG || enc == '0 || enc > SLOT_COUNT)
      return 1'b0;
    idx = int'(enc) - 1;
    return slot_live[idx] && slot_gen[idx] == gen;
  endfunction

  // applies one operation to the shadow table and returns its outcome
  function automatic table_rsp_t table_step(input table_req_t req);
    table_rsp_t rsp;
    int         idx;
    bit         placed;
    rsp.status     = ST_OK;
    rsp.new_handle = '0;
    placed         = 1'b0;
    case (req.op)
      OP_CREATE: begin
        if (req.ver != abi_setting) begin
          rsp.status = ST_BAD_VERSION;
        end else if (req.size < min_size_setting) begin
          rsp.status = ST_TOO_SMALL;
        end else if (req.flags != '0 || req.rsv != '0) begin
          rsp.status = ST_UNSUPPORTED;
        end else begin
          rsp.status = ST_CAPACITY;
          // lowest free slot wins
          for (int i = 0; i < SLOT_COUNT && !placed; i++) begin
            if (!slot_live[i]) begin
              if (slot_gen[i] == '0) slot_gen[i] = 1;
              slot_refs[i]   = '0;
              slot_live[i]   = 1'b1;
              rsp.new_handle = make_handle(slot_gen[i], i);
              rsp.status     = ST_OK;
              placed         = 1'b1;
            end
          end
        end
      end
      OP_DESTROY: begin
        if (!locate_slot(req.handle, idx)) begin
          rsp.status = ST_BAD_HANDLE;
        end else if (slot_refs[idx] != '0) begin
          rsp.status = ST_IN_USE;
        end else begin
          slot_live[idx] = 1'b0;
          slot_gen[idx]  = slot_gen[idx] + 1;
          if (slot_gen[idx] == '0) slot_gen[idx] = 1;
        end
      end
      OP_RETAIN: begin
        if (!locate_slot(req.handle, idx)) begin
          rsp.status = ST_BAD_HANDLE;
        end else if (slot_refs[idx] == COUNT_MAX) begin
          rsp.status = ST_CAPACITY;
        end else begin
          slot_refs[idx] = slot_refs[idx] + 1;
        end
      end
      default: begin
        // release never fails
        if (locate_slot(req.handle, idx) && slot_refs[idx] != '0)
          slot_refs[idx] = slot_refs[idx] - 1;
      end
    endcase
    return rsp;
  endfunction

  function automatic table_req_t mk_item(input logic [OP_W-1:0] op,
                                         input logic [HANDLE_W-1:0] handle,
                                         input logic [WORD_W-1:0] ver,
                                         input logic [WORD_W-1:0] size,
                                         input logic [WORD_W-1:0] flags,
                                         input logic [WORD_W-1:0] rsv);
    table_req_t item;
    item.op     = op;
    item.handle = handle;
    item.ver    = ver;
    item.size   = size;
    item.flags  = flags;
    item.rsv    = rsv;
    return item;
  endfunction

  // mostly well-formed traffic on live handles, some broken creates and noise
  function automatic table_req_t next_random_item();
    table_req_t item;
    int         live[$];
    int         pick;
    int         roll;
    item = mk_item(OP_CREATE, {$urandom, $urandom}, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < SLOT_COUNT; i++)
      if (slot_live[i]) live.push_back(i);
    roll = $urandom_range(0, 99);
    if (roll < 30 || (roll < 88 && live.size() == 0)) begin
      item.op    = OP_CREATE;
      item.ver   = abi_setting;
      item.size  = $urandom_range(32'hffff_ffff, min_size_setting);
      item.flags = '0;
      item.rsv   = '0;
      // break at most one descriptor field now and then
      if ($urandom_range(0, 99) >= 85) begin
        case ($urandom_range(0, 3))
          0: item.ver = abi_setting ^ (32'd1 << $urandom_range(0, 31));
          1: if (min_size_setting != '0) item.size = $urandom_range(min_size_setting - 1, 0);
          2: item.flags = 32'd1 << $urandom_range(0, 31);
          default: item.rsv = 32'd1 << $urandom_range(0, 31);
        endcase
      end
    end else if (roll < 88) begin
      pick        = live[$urandom_range(0, live.size() - 1)];
      item.handle = make_handle(slot_gen[pick], pick);
      item.op     = (roll < 50) ? OP_DESTROY : (roll < 68) ? OP_RETAIN : OP_RELEASE;
    end else begin
      item.op = OP_W'($urandom_range(0, 3));
      if (live.size() != 0 && $urandom_range(0, 1) == 1) begin
        pick        = live[$urandom_range(0, live.size() - 1)];
        item.handle = make_handle(slot_gen[pick], pick) ^ (64'd1 << $urandom_range(0, 63));
      end
    end
    return item;
  endfunction

  // driver: one transaction at a time, random gaps between them
  always @(negedge clk) begin : op_driver
    table_req_t item;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (accept_count == drive_count) begin
      if (op_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        item = op_queue.pop_front();
        in_operation        <= item.op;
        in_handle           <= item.handle;
        in_desc_abi_version <= item.ver;
        in_desc_struct_size <= item.size;
        in_desc_flags       <= item.flags;
        in_desc_reserved    <= item.rsv;
        start               <= 1'b1;
        drive_count++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results in order, predict on each accepted transaction
  always @(posedge clk) begin : result_check
    table_rsp_t want;
    table_req_t seen;
    if (rst_n && out_valid) begin
      if (awaited_outcomes.size() == 0) begin
        $error("unexpected result: status %0d new_handle %h", out_status, out_new_handle);
        err_count++;
      end else begin
        want = awaited_outcomes.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          err_count++;
        end
        if (out_new_handle !== want.new_handle) begin
          $error("new_handle: expected %h, got %h", want.new_handle, out_new_handle);
          err_count++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      seen = mk_item(in_operation, in_handle, in_desc_abi_version, in_desc_struct_size,
                     in_desc_flags, in_desc_reserved);
      awaited_outcomes.push_back(table_step(seen));
      accept_count++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_generational_handle_table: errors");
      $finish;
    end
  end

  // wait until every transaction is taken and every result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (op_queue.size() != 0 || accept_count != drive_count ||
           awaited_outcomes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == CFG_ABI_VERSION) abi_setting = val;
    else min_size_setting = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [WORD_W-1:0] abi, input logic [WORD_W-1:0] min_size,
                           input int gap, input int count);
    write_reg(CFG_ABI_VERSION, abi);
    write_reg(CFG_MIN_SIZE, min_size);
    gap_pct = gap;
    for (int n = 0; n < count; n++) begin
      while (op_queue.size() >= 2) @(posedge clk);
      op_queue.push_back(next_random_item());
      // sender holds off halfway until the table is quiet
      if (n == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  // stimulus sequence
  initial begin
    logic [HANDLE_W-1:0] h1;
    logic [HANDLE_W-1:0] h2;
    rst_n               = 1'b0;
    start               = 1'b0;
    in_operation        = OP_CREATE;
    in_handle           = '0;
    in_desc_abi_version = '0;
    in_desc_struct_size = '0;
    in_desc_flags       = '0;
    in_desc_reserved    = '0;
    cfg_valid           = 1'b0;
    cfg_index           = CFG_ABI_VERSION;
    cfg_data            = '0;
    abi_setting         = CFG_ABI_RESET;
    min_size_setting    = CFG_SIZE_RESET;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_live[i] = 1'b0;
      slot_gen[i]  = '0;
      slot_refs[i] = '0;
    end
    h1 = make_handle(1, 0);
    h2 = make_handle(1, 1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: create checks and their order
    op_queue.push_back(mk_item(OP_CREATE, '0, CFG_ABI_RESET, CFG_SIZE_RESET, '0, '0));
    op_queue.push_back(mk_item(OP_CREATE, '1, CFG_ABI_RESET, '1, '0, '0));
    op_queue.push_back(mk_item(OP_CREATE, '0, '0, CFG_SIZE_RESET, '0, '0));
    op_queue.push_back(mk_item(OP_CREATE, '0, '1, '0, '1, '1));
    op_queue.push_back(mk_item(OP_CREATE, '0, CFG_ABI_RESET, CFG_SIZE_RESET - 1, '1, '0));
    op_queue.push_back(mk_item(OP_CREATE, '0, CFG_ABI_RESET, CFG_SIZE_RESET, '1, '0));
    op_queue.push_back(mk_item(OP_CREATE, '0, CFG_ABI_RESET, CFG_SIZE_RESET, '0, '1));
    // reference counting, destroy refused while in use, stale handle after destroy
    op_queue.push_back(mk_item(OP_RETAIN, h1, '0, '0, '0, '0));
    op_queue.push_back(mk_item(OP_DESTROY, h1, '0, '0, '0, '0));
    op_queue.push_back(mk_item(OP_RELEASE, h1, '0, '0, '0, '0));
    op_queue.push_back(mk_item(OP_RELEASE, h1, '0, '0, '0, '0));
    op_queue.push_back(mk_item(OP_DESTROY, h1, '1, '1, '1, '1));
    op_queue.push_back(mk_item(OP_DESTROY, h1, '0, '0, '0, '0));
    op_queue.push_back(mk_item(OP_RETAIN, h1, '0, '0, '0, '0));
    op_queue.push_back(mk_item(OP_RELEASE, h1, '0, '0, '0, '0));
    op_queue.push_back(mk_item(OP_CREATE, '0, CFG_ABI_RESET, CFG_SIZE_RESET, '0, '0));
    // malformed handles: tag, slot zero, slot out of range, zero and wrong generation
    op_queue.push_back(mk_item(OP_RETAIN, h2 ^ 64'h0000_0000_0100_0000, '0, '0, '0, '0));
    op_queue.push_back(mk_item(OP_DESTROY, make_handle(1, -1), '0, '0, '0, '0));
    op_queue.push_back(mk_item(OP_RETAIN, make_handle(1, SLOT_COUNT), '0, '0, '0, '0));
    op_queue.push_back(mk_item(OP_RETAIN, {32'd1, HANDLE_TAG, 24'hff_ffff}, '0, '0, '0, '0));
    op_queue.push_back(mk_item(OP_RETAIN, make_handle(0, 1), '0, '0, '0, '0));
    op_queue.push_back(mk_item(OP_DESTROY, make_handle(5, 1), '0, '0, '0, '0));
    op_queue.push_back(mk_item(OP_DESTROY, '1, '0, '0, '0, '0));
    op_queue.push_back(mk_item(OP_RELEASE, '0, '1, '1, '1, '1));
    op_queue.push_back(mk_item(OP_DESTROY, h2, '0, '0, '0, '0));
    wait_drained();

    // random phases across settings and idle rates
    run_phase(32'hffff_ffff, 32'h0, 52, 500);
    run_phase(32'h0, 32'hffff_ffff, 13, 500);
    run_phase($urandom, $urandom_range(0, 64), 0, 500);
    run_phase(CFG_ABI_RESET, CFG_SIZE_RESET, 52, 500);

    if (err_count == 0) begin
      $display("tb_generational_handle_table: clean");
    end else begin
      $display("tb_generational_handle_table: errors");
    end
    $finish;
  end

endmodule
